// ===== hw/rtl/igot_pkg.sv =====
// ----------------------------------------------------------------------------
// igot_pkg
// Shared types and constants of the greedy IoU object tracker.
// ----------------------------------------------------------------------------
package igot_pkg;

  localparam logic [15:0] THRESH_RESET = 16'd19661;
  localparam logic [15:0] MAX_AGE_RESET = 16'd500;
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_MAX_AGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_SCAN,
    ST_FLUSH,
    ST_CMP,
    ST_RANK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [7:0]  cls;
    logic [31:0] id;
    logic [31:0] seen;
  } slot_t;

  // Stage-1 result of the IoU datapath for one slot.
  typedef struct packed {
    logic        hit;
    logic [24:0] ov;
    logic [25:0] un;
    logic [31:0] id;
  } cand_t;

endpackage

// ===== hw/rtl/igot_iou.sv =====
// ----------------------------------------------------------------------------
// igot_iou
// Overlap and union areas, class hit and slot id for a detection, registered.
// ----------------------------------------------------------------------------
module igot_iou (
  input  logic            clk,
  input  logic            en,
  input  logic            slot_live,
  input  igot_pkg::slot_t slot,
  input  igot_pkg::box_t  det,
  input  logic [7:0]      det_cls,
  output igot_pkg::cand_t cand_r
);
  import igot_pkg::*;

  logic [12:0] tx2, dx2, ty2, dy2, x1, x2, y1, y2;
  logic [11:0] ow, oh;
  logic [23:0] a1, a2, ovp;
  cand_t       cand_nxt;

  always_comb begin
    tx2 = {1'b0, slot.box.x} + {1'b0, slot.box.w};
    dx2 = {1'b0, det.x} + {1'b0, det.w};
    ty2 = {1'b0, slot.box.y} + {1'b0, slot.box.h};
    dy2 = {1'b0, det.y} + {1'b0, det.h};
    x1 = (slot.box.x > det.x) ? {1'b0, slot.box.x} : {1'b0, det.x};
    y1 = (slot.box.y > det.y) ? {1'b0, slot.box.y} : {1'b0, det.y};
    x2 = (tx2 < dx2) ? tx2 : dx2;
    y2 = (ty2 < dy2) ? ty2 : dy2;
    ow = (x2 > x1) ? 12'(x2 - x1) : 12'd0;
    oh = (y2 > y1) ? 12'(y2 - y1) : 12'd0;
    a1 = slot.box.w * slot.box.h;
    a2 = det.w * det.h;
    ovp = ow * oh;
    cand_nxt.hit = slot_live && (slot.cls == det_cls);
    cand_nxt.ov = {1'b0, ovp};
    cand_nxt.un = 26'({2'b0, a1} + {2'b0, a2} - {2'b0, ovp});
    cand_nxt.id = slot.id;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

endmodule

// ===== hw/rtl/igot_ctrl.sv =====
// ----------------------------------------------------------------------------
// igot_ctrl
// Slot scan sequencer: ages tracks at frame start, picks the best IoU match
// for a detection, updates or allocates a slot and emits the result item.
// ----------------------------------------------------------------------------
module igot_ctrl #(
  parameter int MAX_TRACKS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_op,
  input  logic [31:0]     in_frame_time_ms,
  input  igot_pkg::box_t  det_in,
  input  logic [15:0]     in_det_score,
  input  logic [7:0]      in_det_class,
  input  logic [15:0]     thresh,
  input  logic [15:0]     max_age,
  output logic            out_valid,
  output igot_pkg::box_t  out_box,
  output logic [15:0]     out_score,
  output logic [7:0]      out_class,
  output logic [31:0]     out_track_number,
  output logic            out_is_new,
  output logic            out_table_full
);
  import igot_pkg::*;

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  state_t state_r, state_nxt;
  slot_t mem [MAX_TRACKS];
  slot_t rd_r;
  logic [MAX_TRACKS-1:0] valid_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] rd_idx_r, cmp_idx_r;
  logic rd_live_r, cmp_vld_r;
  logic [31:0] now_r, next_id_r;
  box_t det_r;
  logic [15:0] score_r;
  logic [7:0] cls_r;
  logic best_vld_r;
  logic [IW-1:0] best_idx_r;
  logic [24:0] best_ov_r;
  logic [25:0] best_un_r;
  logic [31:0] best_id_r;
  cand_t cand_r;
  logic [41:0] lhs_r, rhs_r;
  logic [50:0] c1, c2;
  logic cand_ok_r;
  logic [IW-1:0] cand_idx_r;
  cand_t cand2_r;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  slot_t wr_data;
  logic [IW-1:0] free_idx;
  logic free_any;
  logic age_mode_r;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Synchronous slot memory, one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  igot_iou u_iou (
    .clk(clk), .en(1'b1), .slot_live(rd_live_r), .slot(rd_r),
    .det(det_r), .det_cls(cls_r), .cand_r(cand_r)
  );

  // Stage 2: threshold products, a shift for overlap and a multiply for union.
  always_ff @(posedge clk) begin
    lhs_r <= {1'b0, cand_r.ov, 16'd0};
    rhs_r <= 42'(thresh * cand_r.un);
    cand_ok_r <= cmp_vld_r && cand_r.hit && (cand_r.un != '0);
    cand_idx_r <= cmp_idx_r;
    cand2_r <= cand_r;
  end

  // Rank against the current best in the update cycle itself, so a best
  // taken on the previous slot is already seen.
  always_comb begin
    c1 = cand2_r.ov * best_un_r;
    c2 = best_ov_r * cand2_r.un;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    wr_en = 1'b0;
    wr_idx = best_idx_r;
    wr_data.box = det_r;
    wr_data.cls = cls_r;
    wr_data.seen = now_r;
    wr_data.id = best_id_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = in_op ? ST_SCAN : ST_AGE;
        end
      end
      ST_AGE, ST_SCAN: begin
        if (cnt_r == CW'(MAX_TRACKS - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FLUSH: state_nxt = ST_CMP;
      ST_CMP: state_nxt = ST_RANK;
      ST_RANK: state_nxt = ST_DONE;
      ST_DONE: begin
        state_nxt = ST_IDLE;
        if (!age_mode_r) begin
          if (best_vld_r) begin
            wr_en = 1'b1;
          end else if (free_any) begin
            wr_en = 1'b1;
            wr_idx = free_idx;
            wr_data.id = next_id_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      valid_r <= '0;
      now_r <= '0;
      next_id_r <= 32'd1;
      out_valid <= 1'b0;
      rd_live_r <= 1'b0;
      cmp_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      age_mode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid <= 1'b0;
      // Pipeline: address cnt -> rd_r -> cand_r -> products.
      rd_live_r <= (state_r == ST_AGE || state_r == ST_SCAN) && valid_r[cnt_r[IW-1:0]];
      rd_idx_r <= cnt_r[IW-1:0];
      cmp_vld_r <= rd_live_r && !age_mode_r;
      cmp_idx_r <= rd_idx_r;
      if (state_r == ST_IDLE && start) begin
        age_mode_r <= !in_op;
        best_vld_r <= 1'b0;
        best_ov_r <= '0;
        best_un_r <= 26'd1;
        det_r <= det_in;
        score_r <= in_det_score;
        cls_r <= in_det_class;
        if (!in_op) now_r <= in_frame_time_ms;
      end
      // Age out: drop slots older than max_age (uses freshly latched time).
      if (age_mode_r && rd_live_r && ((now_r - rd_r.seen) > {16'd0, max_age})) begin
        valid_r[rd_idx_r] <= 1'b0;
      end
      if (cand_ok_r && (lhs_r > rhs_r) && (!best_vld_r || c1 > c2 ||
          (c1 == c2 && cand2_r.id < best_id_r))) begin
        best_vld_r <= 1'b1;
        best_idx_r <= cand_idx_r;
        best_ov_r <= cand2_r.ov;
        best_un_r <= cand2_r.un;
        best_id_r <= cand2_r.id;
      end
      if (state_r == ST_DONE && !age_mode_r) begin
        out_valid <= 1'b1;
        out_box <= det_r;
        out_score <= score_r;
        out_class <= cls_r;
        out_is_new <= !best_vld_r && free_any;
        out_table_full <= !best_vld_r && !free_any;
        out_track_number <= best_vld_r ? best_id_r : (free_any ? next_id_r : 32'd0);
        if (!best_vld_r && free_any) begin
          valid_r[free_idx] <= 1'b1;
          next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 1'b1;
        end
      end
    end
  end

  // Slot writes happen only in DONE for detections.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_DONE && !age_mode_r))
    else $error("slot write outside a detection commit");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != 32'd0)
    else $error("track id counter hit zero");

endmodule

// ===== hw/rtl/iou_greedy_object_tracker.sv =====
// ----------------------------------------------------------------------------
// iou_greedy_object_tracker
// Track table with greedy IoU association of detections.
// ----------------------------------------------------------------------------
// The block takes no new item while busy. Each item scans every slot
// through the single read port (one slot read per cycle), then drains the
// pipeline through FLUSH, CMP, RANK and DONE. Frame starts take the same
// time and give no result. Reset (rst_n low, synchronous): all slots free,
// next id 1, time 0, configuration registers to defaults. out_valid is a
// one-cycle strobe; the receiver cannot stall it.
module iou_greedy_object_tracker #(
  parameter int MAX_TRACKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_frame_time_ms,
  input  logic [11:0] in_box_x,
  input  logic [11:0] in_box_y,
  input  logic [11:0] in_box_w,
  input  logic [11:0] in_box_h,
  input  logic [15:0] in_det_score,
  input  logic [7:0]  in_det_class,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [11:0] out_w,
  output logic [11:0] out_h,
  output logic [15:0] out_score,
  output logic [7:0]  out_class,
  output logic [31:0] out_track_number,
  output logic        out_is_new,
  output logic        out_table_full
);
  import igot_pkg::*;

  logic [15:0] thresh_r, max_age_r;
  box_t det, obox;

  assign cfg_ready = 1'b1;
  assign det = '{x: in_box_x, y: in_box_y, w: in_box_w, h: in_box_h};

  // Hold the two configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      max_age_r <= MAX_AGE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_THRESH) thresh_r <= cfg_data;
      else max_age_r <= cfg_data;
    end
  end

  igot_ctrl #(.MAX_TRACKS(MAX_TRACKS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_frame_time_ms(in_frame_time_ms), .det_in(det),
    .in_det_score(in_det_score), .in_det_class(in_det_class),
    .thresh(thresh_r), .max_age(max_age_r),
    .out_valid(out_valid), .out_box(obox), .out_score(out_score),
    .out_class(out_class), .out_track_number(out_track_number),
    .out_is_new(out_is_new), .out_table_full(out_table_full)
  );

  assign out_x = obox.x;
  assign out_y = obox.y;
  assign out_w = obox.w;
  assign out_h = obox.h;

endmodule

// ===== tb/iou_greedy_object_tracker_test.sv =====
// ----------------------------------------------------------------------------
// iou_greedy_object_tracker_test
// Drives frame starts and detections into the greedy IoU tracker, keeps its
// own track table to predict every association, and checks each strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module iou_greedy_object_tracker_test;
  import igot_pkg::*;

  localparam int NUM_SLOTS = 32;
  localparam int SCAN_LAT = NUM_SLOTS + 5;
  localparam int IDLE_LIMIT = 20000;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_DET = 1'b1;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [15:0] score;
    logic [7:0]  cls;
    logic [31:0] track;
    logic        is_new;
    logic        full;
  } track_result_t;

  // Own copy of the tracker: table, time, id counter and registers.
  class track_table_sb;
    bit          live[NUM_SLOTS];
    bit [11:0]   sx[NUM_SLOTS], sy[NUM_SLOTS], sw[NUM_SLOTS], sh[NUM_SLOTS];
    bit [7:0]    scls[NUM_SLOTS];
    bit [31:0]   sid[NUM_SLOTS];
    bit [31:0]   sseen[NUM_SLOTS];
    bit [31:0]   next_track;
    bit [31:0]   now;
    bit [15:0]   thresh;
    bit [15:0]   max_age;
    track_result_t pending[$];
    int          errors;
    int          n_new, n_match, n_full, n_frames;

    function void clear();
      foreach (live[i]) live[i] = 1'b0;
      next_track = 32'd1;
      now = 32'd0;
      thresh = THRESH_RESET;
      max_age = MAX_AGE_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic idx, bit [15:0] val);
      if (idx == REG_THRESH) thresh = val;
      else max_age = val;
    endfunction

    // Note an accepted item and queue the association it must produce.
    function void note_item(logic op, bit [31:0] t, bit [11:0] x, bit [11:0] y,
                            bit [11:0] w, bit [11:0] h, bit [15:0] sc, bit [7:0] c);
      int best, free_slot;
      bit [63:0] bov, bun, ov, un, x1, y1, x2, y2, ow, oh;
      track_result_t r;
      best = -1;
      free_slot = -1;
      bov = 0;
      bun = 1;
      if (op == OP_FRAME) begin
        now = t;
        n_frames++;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (live[i] && (now - sseen[i]) > {16'd0, max_age}) live[i] = 1'b0;
        return;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!live[i] || scls[i] != c) continue;
        x1 = (sx[i] > x) ? sx[i] : x;
        y1 = (sy[i] > y) ? sy[i] : y;
        x2 = ((sx[i] + 64'(sw[i])) < (x + 64'(w))) ? sx[i] + 64'(sw[i]) : x + 64'(w);
        y2 = ((sy[i] + 64'(sh[i])) < (y + 64'(h))) ? sy[i] + 64'(sh[i]) : y + 64'(h);
        ow = (x2 > x1) ? x2 - x1 : 0;
        oh = (y2 > y1) ? y2 - y1 : 0;
        ov = ow * oh;
        un = 64'(sw[i]) * sh[i] + 64'(w) * h - ov;
        if (un == 0 || (ov << 16) <= 64'(thresh) * un) continue;
        if (best < 0 || ov * bun > bov * un ||
            (ov * bun == bov * un && sid[i] < sid[best])) begin
          best = i;
          bov = ov;
          bun = un;
        end
      end
      r = '{x: x, y: y, w: w, h: h, score: sc, cls: c, track: 0, is_new: 0, full: 0};
      if (best >= 0) begin
        {sx[best], sy[best], sw[best], sh[best]} = {x, y, w, h};
        sseen[best] = now;
        r.track = sid[best];
        n_match++;
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!live[i]) begin
            free_slot = i;
            break;
          end
        if (free_slot < 0) begin
          r.full = 1'b1;
          n_full++;
        end else begin
          live[free_slot] = 1'b1;
          {sx[free_slot], sy[free_slot], sw[free_slot], sh[free_slot]} = {x, y, w, h};
          scls[free_slot] = c;
          sseen[free_slot] = now;
          sid[free_slot] = next_track;
          r.track = next_track;
          r.is_new = 1'b1;
          next_track++;
          if (next_track == 0) next_track = 32'd1;
          n_new++;
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    // Compare one strobed result with the oldest prediction.
    function void check_result(track_result_t got);
      track_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result track %0d", got.track));
        return;
      end
      exp = pending.pop_front();
      if (got.x != exp.x) report($sformatf("x %0d exp %0d", got.x, exp.x));
      if (got.y != exp.y) report($sformatf("y %0d exp %0d", got.y, exp.y));
      if (got.w != exp.w) report($sformatf("w %0d exp %0d", got.w, exp.w));
      if (got.h != exp.h) report($sformatf("h %0d exp %0d", got.h, exp.h));
      if (got.score != exp.score) report($sformatf("score %0h exp %0h", got.score, exp.score));
      if (got.cls != exp.cls) report($sformatf("class %0d exp %0d", got.cls, exp.cls));
      if (got.track != exp.track)
        report($sformatf("track %0d exp %0d", got.track, exp.track));
      if (got.is_new != exp.is_new) report($sformatf("is_new %0b exp %0b", got.is_new, exp.is_new));
      if (got.full != exp.full) report($sformatf("table_full %0b exp %0b", got.full, exp.full));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_op = 0;
  logic [31:0] in_frame_time_ms = 0;
  logic [11:0] in_box_x = 0, in_box_y = 0, in_box_w = 0, in_box_h = 0;
  logic [15:0] in_det_score = 0;
  logic [7:0]  in_det_class = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        out_valid;
  logic [11:0] out_x, out_y, out_w, out_h;
  logic [15:0] out_score;
  logic [7:0]  out_class;
  logic [31:0] out_track_number;
  logic        out_is_new, out_table_full;

  iou_greedy_object_tracker #(.MAX_TRACKS(NUM_SLOTS)) dut (.*);

  always #5 clk = ~clk;

  track_table_sb sb = new();
  int idle_cycles = 0;
  int items_sent = 0;
  bit [31:0] clock_ms = 0;

  // Check every strobe at the edge that ends it; count idle cycles for the
  // watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{x: out_x, y: out_y, w: out_w, h: out_h, score: out_score,
                          cls: out_class, track: out_track_number,
                          is_new: out_is_new, full: out_table_full});
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", sb.pending.size());
        $display("[iou_greedy_object_tracker] ERROR");
        $finish;
      end
    end
  end

  // Send one item; hold start until the block takes it, then drop it for
  // one cycle.
  task automatic send_item(logic op, bit [31:0] t, bit [11:0] x, bit [11:0] y,
                           bit [11:0] w, bit [11:0] h, bit [15:0] sc, bit [7:0] c);
    start <= 1;
    in_op <= op;
    in_frame_time_ms <= t;
    in_box_x <= x;
    in_box_y <= y;
    in_box_w <= w;
    in_box_h <= h;
    in_det_score <= sc;
    in_det_class <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, t, x, y, w, h, sc, c);
    items_sent++;
    start <= 0;
    @(posedge clk);
  endtask

  task automatic frame_at(bit [31:0] t);
    send_item(OP_FRAME, t, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom), 8'($urandom));
  endtask

  task automatic detect(bit [11:0] x, bit [11:0] y, bit [11:0] w, bit [11:0] h,
                        bit [7:0] c);
    send_item(OP_DET, $urandom, x, y, w, h, 16'($urandom), c);
  endtask

  // Wait for every outstanding result, then let a trailing frame scan finish.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SCAN_LAT + 4) @(posedge clk);
  endtask

  // Write a register only once the block has gone idle.
  task automatic write_reg(logic idx, bit [15:0] val);
    while (busy) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Send a frame, a random box, or a jittered box that often matches a track.
  task automatic random_item(int fill_mode);
    bit [11:0] bx, by, bw, bh;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      clock_ms += $urandom_range(0, 300);
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      frame_at(clock_ms);
    end else if (r < 20) begin
      detect(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 8'($urandom));
    end else begin
      bx = 12'($urandom_range(0, 7) * 500 + $urandom_range(0, 12));
      by = 12'($urandom_range(0, 3) * 900 + $urandom_range(0, 12));
      bw = 12'($urandom_range(40, 120));
      bh = 12'($urandom_range(40, 120));
      if (fill_mode) bx = 12'($urandom);
      detect(bx, by, bw, bh, 8'($urandom_range(0, 3)));
    end
  endtask

  task automatic random_run(int n, int fill_mode);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        random_item(fill_mode);
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  initial begin
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: detection before any frame, extremes, zero-area boxes, time wrap.
    detect(12'd100, 12'd100, 12'd50, 12'd50, 8'd1);
    detect(12'd100, 12'd100, 12'd50, 12'd50, 8'd1);
    detect(12'd102, 12'd100, 12'd50, 12'd50, 8'd2);
    detect(12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
    detect(12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
    detect(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
    detect(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
    detect(12'd0, 12'd0, 12'hFFF, 12'hFFF, 8'hFF);
    send_item(OP_DET, 32'hFFFF_FFFF, 12'd300, 12'd300, 12'd20, 12'd20, 16'hFFFF, 8'd7);
    send_item(OP_DET, 32'd0, 12'd300, 12'd300, 12'd20, 12'd20, 16'h0000, 8'd7);
    frame_at(32'd400);
    frame_at(32'd1000);
    detect(12'd100, 12'd100, 12'd50, 12'd50, 8'd1);
    frame_at(32'hFFFF_FF00);
    detect(12'd100, 12'd100, 12'd50, 12'd50, 8'd1);
    frame_at(32'h0000_0010);
    detect(12'd100, 12'd100, 12'd50, 12'd50, 8'd1);
    drain();

    // Threshold zero and full: repeat, shift and widen one class-9 box.
    write_reg(REG_THRESH, 16'd0);
    write_reg(REG_MAX_AGE, 16'hFFFF);
    detect(12'd500, 12'd500, 12'd40, 12'd40, 8'd9);
    write_reg(REG_THRESH, 16'hFFFF);
    drain();
    detect(12'd500, 12'd500, 12'd40, 12'd40, 8'd9);
    drain();
    write_reg(REG_THRESH, 16'd0);
    detect(12'd520, 12'd500, 12'd40, 12'd40, 8'd9);
    detect(12'd480, 12'd500, 12'd80, 12'd40, 8'd9);
    drain();

    // Fill the table until it reports full, then age everything out.
    write_reg(REG_THRESH, 16'hFFFF);
    for (int i = 0; i < NUM_SLOTS + 3; i++)
      detect(12'(i * 100), 12'd7, 12'd10, 12'd10, 8'd3);
    drain();
    write_reg(REG_MAX_AGE, 16'd0);
    clock_ms = 32'd5000;
    frame_at(clock_ms);
    drain();

    // Random phases over several register settings.
    write_reg(REG_THRESH, THRESH_RESET);
    write_reg(REG_MAX_AGE, MAX_AGE_RESET);
    random_run(170, 0);
    drain();
    write_reg(REG_THRESH, 16'd8000);
    write_reg(REG_MAX_AGE, 16'd2000);
    random_run(150, 1);
    drain();
    write_reg(REG_THRESH, 16'd45000);
    write_reg(REG_MAX_AGE, 16'd100);
    random_run(150, 0);
    drain();
    write_reg(REG_THRESH, 16'hFFFF);
    write_reg(REG_MAX_AGE, 16'hFFFF);
    random_run(40, 1);
    drain();

    $display("items %0d: %0d frames, %0d new tracks, %0d matches, %0d table full",
             items_sent, sb.n_frames, sb.n_new, sb.n_match, sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[iou_greedy_object_tracker] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("[iou_greedy_object_tracker] ERROR");
    end
    $finish;
  end
endmodule

// ===== iou_greedy_object_tracker.f =====
hw/rtl/igot_pkg.sv
hw/rtl/igot_iou.sv
hw/rtl/igot_ctrl.sv
hw/rtl/iou_greedy_object_tracker.sv
tb/iou_greedy_object_tracker_test.sv
